[rtl/cdt_pkg.sv]
// Package for the call stack de-duplication table.
// Field widths, default sizes and result status codes; no dependencies.
`default_nettype none
package cdt_pkg;
  localparam int ADDR_W = 64;
  localparam int ID_W = 16;
  localparam int TABLE_SLOTS_DEF = 64;
  localparam int STACK_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    ST_MATCHED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_DEEP     = 2'd3
  } status_t;
endpackage
`default_nettype wire

[rtl/cdt_if.sv]
// Valid/ready channel interfaces for frames in and results out.
// Depends on cdt_pkg for field widths.
`default_nettype none
interface cdt_in_if;
  logic                      valid;
  logic                      ready;
  logic [cdt_pkg::ADDR_W-1:0] frame_addr;
  logic [cdt_pkg::ID_W-1:0]   stack_id;
  logic                      last_frame;
  modport source(output valid, frame_addr, stack_id, last_frame, input ready);
  modport sink(input valid, frame_addr, stack_id, last_frame, output ready);
endinterface

interface cdt_out_if;
  logic                     valid;
  logic                     ready;
  logic [cdt_pkg::ID_W-1:0] assigned_id;
  logic [cdt_pkg::ID_W-1:0] original_id;
  logic [1:0]               status;
  modport source(output valid, assigned_id, original_id, status, input ready);
  modport sink(input valid, assigned_id, original_id, status, output ready);
endinterface
`default_nettype wire

[rtl/cdt_front.sv]
// Front end: gathers frames into the incoming stack and emits one job per stack.
// Depends on cdt_pkg and cdt_in_if.
`default_nettype none
module cdt_front #(
  parameter int STACK_DEPTH = cdt_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cdt_in_if.sink    frames,
  output logic      job_valid,
  input  wire logic job_ready,
  output logic [STACK_DEPTH*cdt_pkg::ADDR_W+cdt_pkg::ID_W:0] job_data
);
  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int AW = cdt_pkg::ADDR_W;

  logic [FW-1:0] fcount;
  logic          ovf;
  logic [AW-1:0] inc [STACK_DEPTH];
  logic [STACK_DEPTH*AW-1:0] stack_flat;
  logic          room;
  logic          fire;

  assign frames.ready = job_ready;
  assign fire = frames.valid && frames.ready;
  assign room = fcount < FW'(STACK_DEPTH);
  assign job_valid = frames.valid && frames.last_frame;

  always_comb begin
    for (int k = 0; k < STACK_DEPTH; k++) begin
      stack_flat[k*AW +: AW] = (room && fcount == FW'(k)) ? frames.frame_addr : inc[k];
    end
  end

  assign job_data = {ovf || !room, frames.stack_id, stack_flat};

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= '0;
      ovf <= 1'b0;
      for (int k = 0; k < STACK_DEPTH; k++) inc[k] <= '0;
    end else if (fire) begin
      if (frames.last_frame) begin
        fcount <= '0;
        ovf <= 1'b0;
        for (int k = 0; k < STACK_DEPTH; k++) inc[k] <= '0;
      end else if (room) begin
        inc[fcount[IW-1:0]] <= frames.frame_addr;
        fcount <= fcount + FW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/cdt_queue.sv]
// Two-entry job queue between front and back ends.
// Depends on nothing beyond its WIDTH parameter.
`default_nettype none
module cdt_queue #(
  parameter int WIDTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_data = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end
endmodule
`default_nettype wire

[rtl/cdt_back.sv]
// Back end: table memories, match scan, id search, insert and result register.
// Depends on cdt_pkg and cdt_out_if.
`default_nettype none
module cdt_back #(
  parameter int TABLE_SLOTS = cdt_pkg::TABLE_SLOTS_DEF,
  parameter int STACK_DEPTH = cdt_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic      job_ready,
  input  wire logic [STACK_DEPTH*cdt_pkg::ADDR_W+cdt_pkg::ID_W:0] job_data,
  cdt_out_if.source results
);
  localparam int DW = cdt_pkg::ADDR_W;
  localparam int IDW = cdt_pkg::ID_W;
  localparam int ENTRIES = TABLE_SLOTS * STACK_DEPTH;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int JW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MATCH  = 8'b0000_0100,
    S_HITRD  = 8'b0000_1000,
    S_HITGET = 8'b0001_0000,
    S_IDSCAN = 8'b0010_0000,
    S_INSERT = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t state;

  logic [DW-1:0]  stack_mem [ENTRIES];
  logic [IDW-1:0] id_mem [TABLE_SLOTS];
  logic [DW-1:0]  st_rd;
  logic [IDW-1:0] id_rd;
  logic           st_we;
  logic [AW-1:0]  st_wa;
  logic [DW-1:0]  st_wd;
  logic           id_we;
  logic [SW-1:0]  id_wa;
  logic [IDW-1:0] id_wd;
  logic [SW-1:0]  id_ra;

  logic [SW-1:0] s;
  logic [JW-1:0] j;
  logic [AW-1:0] a;
  logic          s_last;
  logic          j_last;
  logic          iss;
  logic          p_v;
  logic [SW-1:0] p_s;
  logic [JW-1:0] p_j;
  logic [AW-1:0] p_a;
  logic          p_s_last;
  logic          p_j_last;

  logic [DW-1:0]  rot [STACK_DEPTH];
  logic           run_ok;
  logic           hit_found;
  logic [SW-1:0]  hit_slot;
  logic           empty_found;
  logic [SW-1:0]  empty_slot;
  logic [AW-1:0]  empty_base;
  logic [IDW-1:0] cand;
  logic           used;
  logic [IDW-1:0] req;
  logic [IDW-1:0] res_id;
  cdt_pkg::status_t res_st;

  logic           o_valid;
  logic [IDW-1:0] o_assigned;
  logic [IDW-1:0] o_original;
  cdt_pkg::status_t o_status;

  logic eq;
  logic ok_now;
  logic hit_now;
  logic empty_now;
  logic id_hit;
  logic pop;
  logic job_ovf;
  logic [IDW-1:0] job_req;

  assign s_last = s == SW'(TABLE_SLOTS - 1);
  assign j_last = j == JW'(STACK_DEPTH - 1);
  assign p_s_last = p_s == SW'(TABLE_SLOTS - 1);
  assign p_j_last = p_j == JW'(STACK_DEPTH - 1);
  assign job_ovf = job_data[STACK_DEPTH*DW+IDW];
  assign job_req = job_data[STACK_DEPTH*DW +: IDW];

  assign eq = st_rd == rot[0];
  assign ok_now = (p_j == '0) ? eq : (run_ok && eq);
  assign hit_now = p_j_last && ok_now && !hit_found;
  assign empty_now = (p_j == '0) && (st_rd == '0) && !empty_found;
  assign id_hit = id_rd == cand;

  assign pop = (state == S_RESULT) && (!o_valid || results.ready);
  assign job_ready = pop;

  assign results.valid = o_valid;
  assign results.assigned_id = o_assigned;
  assign results.original_id = o_original;
  assign results.status = o_status;

  // Memory port control
  always_comb begin
    st_we = 1'b0;
    st_wa = a;
    st_wd = '0;
    id_we = 1'b0;
    id_wa = s;
    id_wd = '0;
    id_ra = (state == S_HITRD) ? hit_slot : s;
    if (state == S_CLEAR) begin
      st_we = 1'b1;
      id_we = (j == '0);
    end else if (state == S_INSERT) begin
      st_we = 1'b1;
      st_wa = empty_base + AW'(j);
      st_wd = rot[0];
      id_we = j_last;
      id_wa = empty_slot;
      id_wd = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) stack_mem[st_wa] <= st_wd;
    st_rd <= stack_mem[a];
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_wa] <= id_wd;
    id_rd <= id_mem[id_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      s <= '0;
      j <= '0;
      a <= '0;
      iss <= 1'b0;
      p_v <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && !pop) o_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          j <= j_last ? '0 : j + JW'(1);
          if (j_last) s <= s_last ? '0 : s + SW'(1);
          a <= (s_last && j_last) ? '0 : a + AW'(1);
          if (s_last && j_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid) begin
            for (int k = 0; k < STACK_DEPTH; k++) rot[k] <= job_data[k*DW +: DW];
            req <= job_req;
            hit_found <= 1'b0;
            empty_found <= 1'b0;
            if (job_ovf) begin
              res_id <= '0;
              res_st <= cdt_pkg::ST_DEEP;
              state <= S_RESULT;
            end else begin
              iss <= 1'b1;
              state <= S_MATCH;
            end
          end
        end
        S_MATCH: begin
          p_v <= iss;
          if (iss) begin
            p_s <= s;
            p_j <= j;
            p_a <= a;
            j <= j_last ? '0 : j + JW'(1);
            if (j_last) s <= s_last ? '0 : s + SW'(1);
            a <= (s_last && j_last) ? '0 : a + AW'(1);
            if (s_last && j_last) iss <= 1'b0;
          end
          if (p_v) begin
            run_ok <= ok_now;
            for (int k = 0; k < STACK_DEPTH - 1; k++) rot[k] <= rot[k+1];
            rot[STACK_DEPTH-1] <= rot[0];
            if (hit_now) begin
              hit_found <= 1'b1;
              hit_slot <= p_s;
            end
            if (empty_now) begin
              empty_found <= 1'b1;
              empty_slot <= p_s;
              empty_base <= p_a;
            end
            if (p_s_last && p_j_last) begin
              if (hit_found || hit_now) begin
                state <= S_HITRD;
              end else if (empty_found || empty_now) begin
                cand <= req;
                used <= 1'b0;
                iss <= 1'b1;
                state <= S_IDSCAN;
              end else begin
                res_id <= '0;
                res_st <= cdt_pkg::ST_FULL;
                state <= S_RESULT;
              end
            end
          end
        end
        S_HITRD: state <= S_HITGET;
        S_HITGET: begin
          res_id <= id_rd;
          res_st <= cdt_pkg::ST_MATCHED;
          state <= S_RESULT;
        end
        S_IDSCAN: begin
          p_v <= iss;
          if (iss) begin
            p_s <= s;
            s <= s_last ? '0 : s + SW'(1);
            if (s_last) iss <= 1'b0;
          end
          if (p_v) begin
            if (p_s_last) begin
              if (used || id_hit) begin
                // Candidate taken: bump it and rescan every slot
                cand <= IDW'(cand + IDW'(1));
                used <= 1'b0;
                iss <= 1'b1;
              end else begin
                j <= '0;
                state <= S_INSERT;
              end
            end else begin
              used <= used || id_hit;
            end
          end
        end
        S_INSERT: begin
          for (int k = 0; k < STACK_DEPTH - 1; k++) rot[k] <= rot[k+1];
          rot[STACK_DEPTH-1] <= rot[0];
          j <= j_last ? '0 : j + JW'(1);
          if (j_last) begin
            res_id <= cand;
            res_st <= cdt_pkg::ST_INSERTED;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!o_valid || results.ready) begin
            o_valid <= 1'b1;
            o_assigned <= res_id;
            o_original <= req;
            o_status <= res_st;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_in_result: assert property (@(posedge clk) disable iff (rst)
    job_ready |-> state == S_RESULT)
    else $error("job taken outside result state");
  a_insert_has_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_INSERT |-> empty_found && !hit_found)
    else $error("insert without a free slot or after a hit");
  a_no_id_on_fail: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_status == cdt_pkg::ST_FULL || o_status == cdt_pkg::ST_DEEP)
      |-> o_assigned == '0)
    else $error("non-zero id on failed stack");
  a_clear_blocks_jobs: assert property (@(posedge clk)
    $past(rst) |-> state == S_CLEAR && !job_ready)
    else $error("clearing pass not entered after reset");
`endif
endmodule
`default_nettype wire

[rtl/call_stack_dedup_table.sv]
// Call stack de-duplication table, top level.
// Frames are taken one per cycle while the job queue has room; a completed stack is matched
// by a scan of every table entry over the single stack memory port, then an id search over
// all slots per id try and an insert of its frames; a too-deep stack goes straight to the result.
// After reset the table memories are cleared before the first stack is processed;
// frames are still taken while the job queue has room.
`default_nettype none
module call_stack_dedup_table #(
  parameter int TABLE_SLOTS = cdt_pkg::TABLE_SLOTS_DEF,
  parameter int STACK_DEPTH = cdt_pkg::STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cdt_in_if.sink    frames,
  cdt_out_if.source results
);
  localparam int JOBW = STACK_DEPTH * cdt_pkg::ADDR_W + cdt_pkg::ID_W + 1;

  logic            push_valid;
  logic            push_ready;
  logic [JOBW-1:0] push_data;
  logic            pop_valid;
  logic            pop_ready;
  logic [JOBW-1:0] pop_data;

  cdt_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
    .clk(clk), .rst(rst), .frames(frames),
    .job_valid(push_valid), .job_ready(push_ready), .job_data(push_data)
  );

  cdt_queue #(.WIDTH(JOBW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  cdt_back #(.TABLE_SLOTS(TABLE_SLOTS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .job_valid(pop_valid), .job_ready(pop_ready), .job_data(pop_data),
    .results(results)
  );
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for call_stack_dedup_table: frames in, stack ids out.
// Depends on cdt_pkg and the cdt_in_if / cdt_out_if channel interfaces.
// A scoreboard class tracks the stack table and queues the expected outcomes.

typedef struct {
  logic [cdt_pkg::ID_W-1:0] assigned_id;
  logic [cdt_pkg::ID_W-1:0] original_id;
  cdt_pkg::status_t         status;
} dedup_outcome_t;

class dedup_scoreboard;
  localparam int SLOTS = cdt_pkg::TABLE_SLOTS_DEF;
  localparam int DEPTH = cdt_pkg::STACK_DEPTH_DEF;

  logic [63:0]    stacks[SLOTS][DEPTH];
  logic [15:0]    ids[SLOTS];
  logic [63:0]    incoming[DEPTH];
  int unsigned    taken;
  bit             too_deep;
  dedup_outcome_t pending[$];
  int             errors;

  function new();
    foreach (stacks[i, j]) stacks[i][j] = '0;
    foreach (ids[i]) ids[i] = '0;
    clear_incoming();
    errors = 0;
  endfunction

  function void clear_incoming();
    foreach (incoming[j]) incoming[j] = '0;
    taken = 0;
    too_deep = 0;
  endfunction

  function logic [15:0] free_id(logic [15:0] id);
    bit used;
    for (int t = 0; t <= SLOTS; t++) begin
      used = 0;
      foreach (ids[i]) if (ids[i] == id) used = 1;
      if (!used) break;
      id = id + 16'd1;
    end
    return id;
  endfunction

  function void note_frame(logic [63:0] addr, logic [15:0] req, logic last);
    dedup_outcome_t o;
    int hit, spare;
    bit same;
    if (taken < DEPTH) begin
      incoming[taken] = addr;
      taken++;
    end else begin
      too_deep = 1;
    end
    if (!last) return;
    o.assigned_id = '0;
    o.original_id = req;
    if (too_deep) begin
      o.status = cdt_pkg::ST_DEEP;
    end else begin
      hit = -1;
      for (int i = 0; i < SLOTS && hit < 0; i++) begin
        same = 1;
        for (int j = 0; j < DEPTH; j++) if (stacks[i][j] != incoming[j]) same = 0;
        if (same) hit = i;
      end
      if (hit >= 0) begin
        o.assigned_id = ids[hit];
        o.status = cdt_pkg::ST_MATCHED;
      end else begin
        spare = -1;
        for (int i = 0; i < SLOTS && spare < 0; i++) if (stacks[i][0] == '0) spare = i;
        if (spare >= 0) begin
          o.assigned_id = free_id(req);
          ids[spare] = o.assigned_id;
          for (int j = 0; j < DEPTH; j++) stacks[spare][j] = incoming[j];
          o.status = cdt_pkg::ST_INSERTED;
        end else begin
          o.status = cdt_pkg::ST_FULL;
        end
      end
    end
    pending.push_back(o);
    clear_incoming();
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic [15:0] assigned, logic [15:0] original, logic [1:0] status);
    dedup_outcome_t o;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result id %0d status %0d", assigned, status));
      return;
    end
    o = pending.pop_front();
    if (assigned !== o.assigned_id)
      report($sformatf("assigned_id %0d, want %0d", assigned, o.assigned_id));
    if (original !== o.original_id)
      report($sformatf("original_id %0d, want %0d", original, o.original_id));
    if (status !== o.status)
      report($sformatf("status %0d, want %0d", status, o.status));
  endtask
endclass

module testbench;
  localparam int LIMIT = 40000000;
  localparam int POOL = 32;
  localparam int MAXLEN = 20;

  logic clk = 0;
  logic rst = 1;
  cdt_in_if  frames();
  cdt_out_if results();

  call_stack_dedup_table i_dut (.clk(clk), .rst(rst), .frames(frames), .results(results));

  dedup_scoreboard table_model = new();

  always #5 clk = ~clk;

  int  cycles = 0;
  bit  idle_on = 1;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  hold_left = 0;
  int  sent = 0;

  logic [63:0] pool_frames[POOL][MAXLEN];
  int          pool_len[POOL];
  int          pool_n = 0;
  int          pool_wr = 0;
  logic [63:0] cur[$];

  initial begin
    frames.valid = 0;
    frames.frame_addr = '0;
    frames.stack_id = '0;
    frames.last_frame = 0;
    results.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      table_model.check_result(results.assigned_id, results.original_id, results.status);
    if (hold_req && !hold_done) begin
      hold_left = 4000;
      hold_done = 1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      results.ready <= 0;
    end else begin
      results.ready <= !(idle_on && $urandom_range(99) < 28);
    end
  end

  task send_frame(logic [63:0] addr, logic [15:0] req, logic last);
    if (idle_on && $urandom_range(99) < 28) begin
      frames.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    frames.valid <= 1;
    frames.frame_addr <= addr;
    frames.stack_id <= req;
    frames.last_frame <= last;
    @(posedge clk);
    while (!frames.ready) @(posedge clk);
    table_model.note_frame(addr, req, last);
    sent++;
  endtask

  task send_stack(logic [15:0] req);
    foreach (cur[k]) send_frame(cur[k], req, k == cur.size() - 1);
  endtask

  function logic [63:0] rand_addr();
    case ($urandom_range(9))
      0: return '1;
      1: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function logic [15:0] rand_req();
    case ($urandom_range(5))
      0: return 16'hFFFF;
      1: return 16'hFFFE;
      2: return 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  function void remember();
    if (cur.size() > cdt_pkg::STACK_DEPTH_DEF || cur.size() == 0) return;
    foreach (cur[k]) pool_frames[pool_wr][k] = cur[k];
    pool_len[pool_wr] = cur.size();
    pool_wr = (pool_wr + 1) % POOL;
    if (pool_n < POOL) pool_n++;
  endfunction

  task fill(int len, logic [63:0] root);
    cur.delete();
    cur.push_back(root);
    for (int k = 1; k < len; k++) cur.push_back(rand_addr());
  endtask

  task build_random();
    int r, p, len;
    r = $urandom_range(99);
    if (r < 55 && pool_n > 0) begin
      p = $urandom_range(pool_n - 1);
      cur.delete();
      for (int k = 0; k < pool_len[p]; k++) cur.push_back(pool_frames[p][k]);
      // near miss: alter one frame, or drop or add a tail frame
      if (r >= 45) begin
        case ($urandom_range(2))
          0: cur[$urandom_range(cur.size() - 1)] ^= 64'd1 << $urandom_range(63);
          1: if (cur.size() > 1) void'(cur.pop_back());
          default: if (cur.size() < cdt_pkg::STACK_DEPTH_DEF) cur.push_back(rand_addr());
        endcase
        if (cur[0] == '0) cur[0] = 64'd1;
        remember();
      end
    end else if (r < 62) begin
      fill($urandom_range(1, 6), '0);
    end else if (r < 66) begin
      cur.delete();
      repeat ($urandom_range(1, 4)) cur.push_back('0);
    end else if (r < 71) begin
      fill($urandom_range(17, MAXLEN), rand_addr());
    end else begin
      len = ($urandom_range(19) == 0) ? cdt_pkg::STACK_DEPTH_DEF : $urandom_range(1, 8);
      fill(len, rand_addr());
      if (cur[0] == '0) cur[0] = 64'd1;
      remember();
    end
  endtask

  int stacks_done;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: extremes, match, empty-slot match, zero root, id wrap, too deep
    cur = '{64'hFFFF_FFFF_FFFF_FFFF};
    send_stack(16'hFFFF);
    send_stack(16'd5);
    cur = '{64'd0};
    send_stack(16'd0);
    cur = '{64'd0, 64'h8000_0000_0000_0000};
    send_stack(16'd0);
    cur = '{64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    send_stack(16'hFFFF);
    cur = '{64'h8000_0000_0000_0000, 64'd1};
    send_stack(16'hFFFE);
    fill(17, 64'h1234_5678_9ABC_DEF0);
    send_stack(16'hAAAA);

    stacks_done = 0;
    while (sent < 1850) begin
      idle_on = !(sent > 700 && sent < 1000);
      if (stacks_done == 120) hold_req = 1;
      if (stacks_done == 125) hold_req = 0;
      if (stacks_done == 250) begin
        frames.valid <= 0;
        @(posedge clk);
        wait (table_model.pending.size() == 0);
      end
      build_random();
      send_stack(rand_req());
      stacks_done++;
    end

    frames.valid <= 0;
    wait (table_model.pending.size() == 0);
    repeat (300) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

[call_stack_dedup_table.f]
rtl/cdt_pkg.sv
rtl/cdt_if.sv
rtl/cdt_front.sv
rtl/cdt_queue.sv
rtl/cdt_back.sv
rtl/call_stack_dedup_table.sv
test/testbench.sv
